>>> src/lobm_pkg.sv
// ---------------------------------------------------------------------------
// lobm_pkg
// Shared codes, defaults and controller/datapath interface structs for the
// limit order book matcher.
// ---------------------------------------------------------------------------
package lobm_pkg;

  localparam int DEF_ORDER_SLOTS = 64;
  localparam int DEF_PRICE_BITS  = 16;
  localparam int DEF_QTY_BITS    = 32;

  localparam logic [1:0] CMD_LIMIT  = 2'd0;
  localparam logic [1:0] CMD_MARKET = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_QTY  = 3'd1;
  localparam logic [2:0] ST_DUP_ID    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BOOK_FULL = 3'd4;

  typedef logic [1:0] scan_mode_t;
  localparam scan_mode_t SCAN_ID    = 2'd0;
  localparam scan_mode_t SCAN_MATCH = 2'd1;
  localparam scan_mode_t SCAN_BOOK  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       cancel;
    logic       fill;
    logic       rest;
    logic       set_status;
    logic [2:0] status;
    logic       emit;
  } lobm_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       qty_zero;
    logic       scan_done;
    logic       id_found;
    logic       best_found;
    logic       crosses;
    logic       rem_zero;
    logic       k_full;
    logic       pend_valid;
    logic       out_free;
  } lobm_sts_t;

endpackage

>>> src/lobm_ctrl.sv
// ---------------------------------------------------------------------------
// lobm_ctrl
// Command sequencer: id search, repeated best-maker scans with fills, resting,
// final book scan and result emission.
// ---------------------------------------------------------------------------
module lobm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lobm_pkg::lobm_sts_t sts,
  output lobm_pkg::lobm_cmd_t cmd
);
  import lobm_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_IDSCAN   = 4'd2;
  localparam logic [3:0] S_IDEVAL   = 4'd3;
  localparam logic [3:0] S_MSTART   = 4'd4;
  localparam logic [3:0] S_MSCAN    = 4'd5;
  localparam logic [3:0] S_MEVAL    = 4'd6;
  localparam logic [3:0] S_REST     = 4'd7;
  localparam logic [3:0] S_BSCAN    = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.cmd)
          CMD_CANCEL: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_ID;
            state_nxt      = S_IDSCAN;
          end
          CMD_LIMIT: begin
            cmd.scan_start = 1'b1;
            if (sts.qty_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_ZERO_QTY;
              cmd.scan_mode  = SCAN_BOOK;
              state_nxt      = S_BSCAN;
            end else begin
              cmd.scan_mode = SCAN_ID;
              state_nxt     = S_IDSCAN;
            end
          end
          CMD_MARKET: state_nxt = S_MSTART;
          default: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_BOOK;
            state_nxt      = S_BSCAN;
          end
        endcase
      end
      S_IDSCAN: if (sts.scan_done) state_nxt = S_IDEVAL;
      S_IDEVAL: begin
        if (sts.cmd == CMD_CANCEL) begin
          cmd.cancel     = sts.id_found;
          cmd.set_status = 1'b1;
          cmd.status     = sts.id_found ? ST_OK : ST_NOT_FOUND;
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SCAN_BOOK;
          state_nxt      = S_BSCAN;
        end else if (sts.id_found) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_DUP_ID;
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SCAN_BOOK;
          state_nxt      = S_BSCAN;
        end else begin
          state_nxt = S_MSTART;
        end
      end
      S_MSTART: begin
        if (sts.rem_zero || sts.k_full) begin
          state_nxt = S_REST;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SCAN_MATCH;
          state_nxt      = S_MSCAN;
        end
      end
      S_MSCAN: if (sts.scan_done) state_nxt = S_MEVAL;
      S_MEVAL: begin
        if (!sts.best_found || !sts.crosses) begin
          state_nxt = S_REST;
        end else if (!sts.pend_valid || sts.out_free) begin
          // previous fill goes out as a non-final trade
          cmd.fill  = 1'b1;
          state_nxt = S_MSTART;
        end
      end
      S_REST: begin
        cmd.rest       = 1'b1;
        cmd.scan_start = 1'b1;
        cmd.scan_mode  = SCAN_BOOK;
        state_nxt      = S_BSCAN;
      end
      S_BSCAN: if (sts.scan_done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> src/lobm_dp.sv
// ---------------------------------------------------------------------------
// lobm_dp
// Slot store, valid bits, one-slot-per-cycle scan unit with best-order
// trackers, fill/rest arithmetic and the result register.
// ---------------------------------------------------------------------------
module lobm_dp #(
  parameter int ORDER_SLOTS = lobm_pkg::DEF_ORDER_SLOTS,
  parameter int PRICE_BITS  = lobm_pkg::DEF_PRICE_BITS,
  parameter int QTY_BITS    = lobm_pkg::DEF_QTY_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lobm_pkg::lobm_cmd_t cmd,
  output lobm_pkg::lobm_sts_t sts,
  input  logic [1:0]          in_cmd,
  input  logic [31:0]         in_order_id,
  input  logic                in_side,
  input  logic [15:0]         in_price,
  input  logic [31:0]         in_qty,
  input  logic [47:0]         in_timestamp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_maker_id,
  output logic [31:0]         out_aggressor_id,
  output logic [15:0]         out_trade_price,
  output logic [31:0]         out_fill_qty,
  output logic [47:0]         out_trade_time,
  output logic [2:0]          out_status,
  output logic [31:0]         out_rested_qty,
  output logic [15:0]         out_top_bid,
  output logic                out_bid_valid,
  output logic [15:0]         out_top_ask,
  output logic                out_ask_valid,
  output logic                out_last
);
  import lobm_pkg::*;

  localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int PW = PRICE_BITS;
  localparam int QW = QTY_BITS;
  // entry layout: {id, side, price, qty, arrival}
  localparam int EW     = 32 + 1 + PW + QW + 32;
  localparam int O_ARR  = 0;
  localparam int O_QTY  = 32;
  localparam int O_PRC  = 32 + QW;
  localparam int O_SIDE = 32 + QW + PW;
  localparam int O_ID   = 33 + QW + PW;
  localparam logic [IW:0] SLOTS = (IW+1)'(ORDER_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(ORDER_SLOTS - 1);

  // command context
  logic [1:0]  cmd_r;
  logic [31:0] id_r;
  logic        side_r;
  logic [PW-1:0] price_r;
  logic [QW-1:0] rem_r;
  logic [47:0] ts_r;
  logic [2:0]  status_r;
  logic [QW-1:0] rested_r;
  logic [IW:0] k_r;
  logic [31:0] ctr_r;

  logic [EW-1:0] mem [ORDER_SLOTS];
  logic [ORDER_SLOTS-1:0] valid_r;
  logic          we;
  logic [IW-1:0] wa;
  logic [EW-1:0] wd;

  // scan unit
  scan_mode_t    mode_r;
  logic          act_r;
  logic [IW:0]   sc_r;
  logic          rdv_r;
  logic [IW-1:0] rda_r;
  logic [EW-1:0] rd_q;

  // trackers
  logic          found_r;
  logic [IW-1:0] fidx_r;
  logic          bf_r;
  logic [IW-1:0] bidx_r;
  logic [EW-1:0] bent_r;
  logic [31:0]   bage_r;
  logic          bidv_r, askv_r;
  logic [PW-1:0] bidp_r, askp_r;

  // pending trade
  logic          pend_r;
  logic [31:0]   pmaker_r;
  logic [PW-1:0] pprice_r;
  logic [QW-1:0] pfill_r;

  // result register
  logic          ov_r;
  logic [31:0]   o_maker_r, o_taker_r, o_fill_r, o_rested_r;
  logic [15:0]   o_price_r, o_bid_r, o_ask_r;
  logic [47:0]   o_time_r;
  logic [2:0]    o_status_r;
  logic          o_bidv_r, o_askv_r, o_last_r;

  logic [31:0]   e_id;
  logic          e_side;
  logic [PW-1:0] e_price;
  logic [31:0]   e_age;
  logic          e_v;
  logic          better;
  logic [PW-1:0] bp;
  logic [QW-1:0] bq, fq, nq;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          out_free;
  logic          sel_id, sel_best, sel_bid, sel_ask;

  assign e_id    = rd_q[O_ID +: 32];
  assign e_side  = rd_q[O_SIDE];
  assign e_price = rd_q[O_PRC +: PW];
  assign e_age   = ctr_r - rd_q[O_ARR +: 32];
  assign e_v     = rdv_r & valid_r[rda_r];
  assign bp      = bent_r[O_PRC +: PW];
  assign bq      = bent_r[O_QTY +: QW];
  assign fq      = (rem_r < bq) ? rem_r : bq;
  assign nq      = bq - fq;
  assign out_free = !ov_r || !out_stall;

  always_comb begin
    if (side_r) better = (e_price > bp) || (e_price == bp && e_age > bage_r);
    else        better = (e_price < bp) || (e_price == bp && e_age > bage_r);
  end

  assign sel_id   = e_v && mode_r == SCAN_ID && e_id == id_r && !found_r;
  assign sel_best = e_v && mode_r == SCAN_MATCH && e_side == !side_r && (!bf_r || better);
  assign sel_bid  = e_v && mode_r == SCAN_BOOK && !e_side && (!bidv_r || e_price > bidp_r);
  assign sel_ask  = e_v && mode_r == SCAN_BOOK && e_side && (!askv_r || e_price < askp_r);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.cmd        = cmd_r;
    sts.qty_zero   = (rem_r == '0);
    sts.scan_done  = rdv_r && (rda_r == LAST_IDX);
    sts.id_found   = found_r;
    sts.best_found = bf_r;
    if (cmd_r == CMD_MARKET) sts.crosses = 1'b1;
    else if (side_r)         sts.crosses = !(price_r > bp);
    else                     sts.crosses = !(price_r < bp);
    sts.rem_zero   = (rem_r == '0);
    sts.k_full     = (k_r == SLOTS);
    sts.pend_valid = pend_r;
    sts.out_free   = out_free;
  end

  // store write port
  always_comb begin
    we = 1'b0;
    wa = bidx_r;
    wd = {bent_r[EW-1:O_QTY+QW], nq, bent_r[O_ARR +: 32]};
    if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.rest && cmd_r == CMD_LIMIT && rem_r != '0 && free_found) begin
      we = 1'b1;
      wa = free_idx;
      wd = {id_r, side_r, price_r, rem_r, ctr_r};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[sc_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ctr_r   <= '0;
    end else if (cmd.cancel) begin
      valid_r[fidx_r] <= 1'b0;
    end else if (cmd.fill) begin
      if (nq == '0) valid_r[bidx_r] <= 1'b0;
    end else if (cmd.rest && cmd_r == CMD_LIMIT && rem_r != '0 && free_found) begin
      valid_r[free_idx] <= 1'b1;
      ctr_r <= ctr_r + 32'd1;
    end
  end

  // scan sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= act_r;
      if (cmd.scan_start) begin
        act_r <= 1'b1;
      end else if (act_r && sc_r[IW-1:0] == LAST_IDX) begin
        act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rda_r <= sc_r[IW-1:0];
    if (cmd.scan_start) begin
      sc_r   <= '0;
      mode_r <= cmd.scan_mode;
    end else if (act_r) begin
      sc_r <= sc_r + (IW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      found_r <= 1'b0;
      bf_r    <= 1'b0;
      bidv_r  <= 1'b0;
      askv_r  <= 1'b0;
    end else begin
      if (sel_id) begin
        found_r <= 1'b1;
        fidx_r  <= rda_r;
      end
      if (sel_best) begin
        bf_r   <= 1'b1;
        bidx_r <= rda_r;
        bent_r <= rd_q;
        bage_r <= e_age;
      end
      if (sel_bid) begin
        bidv_r <= 1'b1;
        bidp_r <= e_price;
      end
      if (sel_ask) begin
        askv_r <= 1'b1;
        askp_r <= e_price;
      end
    end
  end

  // command context and fills
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (cmd.load) begin
      pend_r <= 1'b0;
    end else if (cmd.fill) begin
      pend_r <= 1'b1;
    end else if (cmd.emit) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_cmd;
      id_r     <= in_order_id;
      side_r   <= in_side;
      price_r  <= PW'(in_price);
      rem_r    <= QW'(in_qty);
      ts_r     <= in_timestamp;
      status_r <= ST_OK;
      rested_r <= '0;
      k_r      <= '0;
    end else begin
      if (cmd.set_status) status_r <= cmd.status;
      if (cmd.fill) begin
        rem_r    <= rem_r - fq;
        k_r      <= k_r + (IW+1)'(1);
        pmaker_r <= bent_r[O_ID +: 32];
        pprice_r <= bp;
        pfill_r  <= fq;
      end
      if (cmd.rest && cmd_r == CMD_LIMIT && rem_r != '0) begin
        if (free_found) rested_r <= rem_r;
        else            status_r <= ST_BOOK_FULL;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if ((cmd.fill && pend_r) || cmd.emit) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.fill && pend_r) || cmd.emit) begin
      o_maker_r  <= pend_r ? pmaker_r : 32'd0;
      o_taker_r  <= id_r;
      o_price_r  <= pend_r ? 16'(pprice_r) : 16'd0;
      o_fill_r   <= pend_r ? 32'(pfill_r) : 32'd0;
      o_time_r   <= ts_r;
      o_status_r <= cmd.emit ? status_r : ST_OK;
      o_rested_r <= cmd.emit ? 32'(rested_r) : 32'd0;
      o_bid_r    <= (cmd.emit && bidv_r) ? 16'(bidp_r) : 16'd0;
      o_bidv_r   <= cmd.emit && bidv_r;
      o_ask_r    <= (cmd.emit && askv_r) ? 16'(askp_r) : 16'd0;
      o_askv_r   <= cmd.emit && askv_r;
      o_last_r   <= cmd.emit;
    end
  end

  assign out_valid        = ov_r;
  assign out_maker_id     = o_maker_r;
  assign out_aggressor_id = o_taker_r;
  assign out_trade_price  = o_price_r;
  assign out_fill_qty     = o_fill_r;
  assign out_trade_time   = o_time_r;
  assign out_status       = o_status_r;
  assign out_rested_qty   = o_rested_r;
  assign out_top_bid      = o_bid_r;
  assign out_bid_valid    = o_bidv_r;
  assign out_top_ask      = o_ask_r;
  assign out_ask_valid    = o_askv_r;
  assign out_last         = o_last_r;

endmodule

>>> src/limit_order_book_matcher_core.sv
// ---------------------------------------------------------------------------
// limit_order_book_matcher_core
// Single-instrument price-time priority order book and matching engine.
// ---------------------------------------------------------------------------
// One command is processed at a time. The slot store is read one slot per
// cycle in every scan of the book. A cancel runs an id scan and a book scan.
// A limit order runs an id scan, then one match round per fill, plus one more
// round that finds no crossing maker unless the order fills completely, then a
// book scan for best bid/ask. A market order skips the id scan. A fill waits
// while the previous trade still sits in a stalled output register, and so
// does the final result. A command yields one result per fill, the last one
// flagged, or a single status-only result. Input is taken again in the cycle
// after the final result enters the output register.
module limit_order_book_matcher_core #(
  parameter int ORDER_SLOTS = lobm_pkg::DEF_ORDER_SLOTS,
  parameter int PRICE_BITS  = lobm_pkg::DEF_PRICE_BITS,
  parameter int QTY_BITS    = lobm_pkg::DEF_QTY_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_order_id,
  input  logic        in_side,
  input  logic [15:0] in_price,
  input  logic [31:0] in_qty,
  input  logic [47:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_maker_id,
  output logic [31:0] out_aggressor_id,
  output logic [15:0] out_trade_price,
  output logic [31:0] out_fill_qty,
  output logic [47:0] out_trade_time,
  output logic [2:0]  out_status,
  output logic [31:0] out_rested_qty,
  output logic [15:0] out_top_bid,
  output logic        out_bid_valid,
  output logic [15:0] out_top_ask,
  output logic        out_ask_valid,
  output logic        out_last
);
  import lobm_pkg::*;

  lobm_cmd_t cmd;
  lobm_sts_t sts;

  lobm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lobm_dp #(
    .ORDER_SLOTS (ORDER_SLOTS),
    .PRICE_BITS  (PRICE_BITS),
    .QTY_BITS    (QTY_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_order_id      (in_order_id),
    .in_side          (in_side),
    .in_price         (in_price),
    .in_qty           (in_qty),
    .in_timestamp     (in_timestamp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_maker_id     (out_maker_id),
    .out_aggressor_id (out_aggressor_id),
    .out_trade_price  (out_trade_price),
    .out_fill_qty     (out_fill_qty),
    .out_trade_time   (out_trade_time),
    .out_status       (out_status),
    .out_rested_qty   (out_rested_qty),
    .out_top_bid      (out_top_bid),
    .out_bid_valid    (out_bid_valid),
    .out_top_ask      (out_top_ask),
    .out_ask_valid    (out_ask_valid),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  a_fill_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fill && sts.pend_valid) |-> sts.out_free)
    else $error("fill would overwrite an untaken result");

  a_emit_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("final result issued while output register busy");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> cmd.load)
    else $error("input transfer without command load");

  a_fill_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> (sts.best_found && sts.crosses && !sts.rem_zero))
    else $error("fill without a crossing maker");
`endif

endmodule
